// ===== rtl/keyed_byte_scrambler_macros.svh =====
// Assertion macros shared by the keyed byte scrambler RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef KEYED_BYTE_SCRAMBLER_MACROS_SVH
`define KEYED_BYTE_SCRAMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KBS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed_byte_scrambler: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KBS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed_byte_scrambler: next-cycle check failed");

`endif

// ===== rtl/kbs_pkg.sv =====
// Shared types, constants and helpers of the keyed byte scrambler.
// No dependencies; used by every module of the block.
package kbs_pkg;

   localparam int BYTE_W          = 8;
   localparam int BLOCK_BYTES     = 8;
   localparam int KEY_W           = 64;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 2;
   localparam int LENGTH_BITS_DEF = 32;
   localparam int LENGTH_REG_MAX  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY       = 2'd0,
      CSR_LENGTH    = 2'd1,
      CSR_DIRECTION = 2'd2
   } csr_index_type;

   // One complete block waiting to be transformed and emitted.
   typedef struct packed {
      logic [BLOCK_BYTES-1:0][BYTE_W-1:0] data;  // raw input bytes
      logic [3:0]                         fill;  // bytes held, 1..8
      logic                               swap;  // trade offsets 0 and s
      logic                               last;  // block ends the stream
      logic [KEY_W-1:0]                   prod;  // block base times key
   } block_type;

   // Remainder by 7 of a 32-bit value: 8 = 1 mod 7, so fold octal digits.
   function automatic logic [2:0] mod7(input logic [31:0] v);
      logic [32:0] w;
      logic [6:0]  r1;
      logic [3:0]  r2;
      logic [3:0]  r3;
      w  = {1'b0, v};
      r1 = '0;
      for (int i = 0; i < 11; i++) begin
         r1 = r1 + 7'(w[3*i +: 3]);
      end
      r2 = 4'(r1[2:0]) + 4'(r1[5:3]) + 4'(r1[6]);
      r3 = 4'(r2[2:0]) + 4'(r2[3]);
      if (r3 >= 4'd7) begin
         r3 = r3 - 4'd7;
      end
      return r3[2:0];
   endfunction

endpackage

// ===== rtl/keyed_byte_scrambler.sv =====
// Top level of the keyed byte scrambler: buffering, block queue and output run.
// Depends on kbs_pkg, kbs_mul, kbs_block_xform and keyed_byte_scrambler_macros.svh.
//
// The block takes one file byte per cycle and returns the same number of bytes, one
// per cycle while rsp_stall is low, in file order. Byte i is XORed with byte (i mod 8)
// of i*key, and in every 8-byte block that is not the stream's final one the bytes at
// offsets 0 and 1 + length%7 trade places (encode XORs before the swap, decode after).
// Bytes are gathered per block; a block leaves as a run once it holds eight bytes or
// the stream ends, with run_last on its last byte and stream_end on the stream's
// final byte. Sustained rate is one request per cycle: a finished block goes into a
// two-entry queue, and the output register drains a run while the next block fills.
// A block's first byte appears once it has passed the queue and the output register.
// Requests stall only when a block completes with the queue full, and after a key
// or length write while the shift-add multiplier rebuilds base*key for the block
// being gathered; that product then advances by 8*key per block with a single add.
`include "keyed_byte_scrambler_macros.svh"

module keyed_byte_scrambler #(
   parameter int LENGTH_BITS = kbs_pkg::LENGTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kbs_pkg::BYTE_W-1:0]          req_in_byte,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kbs_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic                                rsp_run_last,
   output logic                                rsp_stream_end,
   // register writes
   input  logic                                csr_wr_en,
   input  logic [kbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kbs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int LB        = LENGTH_BITS;
   localparam int LEN_REG_W = (LB < kbs_pkg::LENGTH_REG_MAX) ? LB : kbs_pkg::LENGTH_REG_MAX;
   localparam int NB        = kbs_pkg::BLOCK_BYTES;
   localparam int KW        = kbs_pkg::KEY_W;
   localparam int BW        = kbs_pkg::BYTE_W;

   // configuration
   logic [KW-1:0]        key_ff, key3_ff, key5_ff, key7_ff;
   logic [LEN_REG_W-1:0] length_ff;
   logic                 dir_ff;
   logic [2:0]           swap_pos_ff;

   // stream position and gathering buffer
   logic [LB-1:0]        pos_ff;
   logic [LB-1:0]        blk_base_ff;
   logic [2:0]           fill_ff;
   logic [KW-1:0]        prod_ff;
   logic [BW-1:0]        blk_buf_ff [NB];

   // queue of complete blocks, head in slot 0
   kbs_pkg::block_type   q_ff [2];
   kbs_pkg::block_type   q_in [2];
   logic [1:0]           qv_ff;
   logic [1:0]           qv_in;

   // output run register
   logic [NB-1:0][BW-1:0] s_data_ff;
   logic [3:0]            s_fill_ff;
   logic [2:0]            s_idx_ff;
   logic                  s_end_ff;
   logic                  s_valid_ff;

   logic                  req_accept, rsp_accept;
   logic [LB:0]           len_ext;
   logic                  at_end, complete, swap_now, push, s_load, run_last;
   logic [3:0]            fill_new;
   kbs_pkg::block_type    rec;

   logic                  key_wr, len_wr, mul_start, mul_busy, mul_done;
   logic [LEN_REG_W-1:0]  len_new;
   logic [LB-1:0]         pos_eff, mul_base;
   logic [KW-1:0]         mul_key, mul_product;

   logic [NB-1:0][KW-1:0] key_mul;
   logic [NB-1:0][BW-1:0] xf_data;

   // ---------------------------------------------------------------- request side
   assign req_accept = req_valid && !req_stall;
   assign len_ext    = (LB+1)'(length_ff);
   // a zero length ends the stream at every byte
   assign at_end     = ({1'b0, pos_ff} + (LB+1)'(1)) >= len_ext;
   assign complete   = (fill_ff == 3'(NB - 1)) || at_end;
   assign fill_new   = {1'b0, fill_ff} + 4'd1;
   // the final block is never swapped
   assign swap_now   = (({1'b0, blk_base_ff} + (LB+1)'(NB)) < len_ext)
                       && ({1'b0, swap_pos_ff} < fill_new);
   assign push       = req_accept && complete;
   // hold requests while the product is rebuilt, or when a block has no room
   assign req_stall  = mul_busy || (complete && qv_ff[1]);

   always_comb begin
      for (int k = 0; k < NB; k++) begin
         rec.data[k] = (3'(k) == fill_ff) ? req_in_byte : blk_buf_ff[k];
      end
      rec.fill = fill_new;
      rec.swap = swap_now;
      rec.last = at_end;
      rec.prod = prod_ff;
   end

   // ---------------------------------------------------------------- register writes
   assign key_wr    = csr_wr_en && (csr_index == kbs_pkg::CSR_KEY);
   assign len_wr    = csr_wr_en && (csr_index == kbs_pkg::CSR_LENGTH);
   assign len_new   = csr_wdata[LEN_REG_W-1:0];
   assign mul_start = key_wr || len_wr;
   assign mul_key   = key_wr ? csr_wdata : key_ff;

   // a zero length counts the buffered bytes back from position zero
   always_comb begin
      if ((len_wr && len_new == '0) || (!len_wr && length_ff == '0)) begin
         pos_eff = '0;
      end else begin
         pos_eff = pos_ff;
      end
      mul_base = pos_eff - LB'(fill_ff);
   end

   kbs_mul #(
      .MPLIER_W     (LB)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .start_mcand  (mul_key),
      .start_mplier (mul_base),
      .busy         (mul_busy),
      .done         (mul_done),
      .product      (mul_product)
   );

   // d * key for each block offset
   always_comb begin
      key_mul[0] = '0;
      key_mul[1] = key_ff;
      key_mul[2] = key_ff << 1;
      key_mul[3] = key3_ff;
      key_mul[4] = key_ff << 2;
      key_mul[5] = key5_ff;
      key_mul[6] = key3_ff << 1;
      key_mul[7] = key7_ff;
   end

   // ---------------------------------------------------------------- queue and output
   assign rsp_accept = s_valid_ff && !rsp_stall;
   assign run_last   = ({1'b0, s_idx_ff} + 4'd1) == s_fill_ff;
   assign s_load     = qv_ff[0] && (!s_valid_ff || (rsp_accept && run_last));

   always_comb begin
      q_in  = q_ff;
      qv_in = qv_ff;
      // advance the queue when the head moves to the output register
      if (s_load) begin
         q_in[0]  = q_ff[1];
         qv_in[0] = qv_ff[1];
         qv_in[1] = 1'b0;
      end
      if (push) begin
         if (!qv_in[0]) begin
            q_in[0]  = rec;
            qv_in[0] = 1'b1;
         end else begin
            q_in[1]  = rec;
            qv_in[1] = 1'b1;
         end
      end
   end

   kbs_block_xform u_xform (
      .blk      (q_ff[0]),
      .key_mul  (key_mul),
      .swap_pos (swap_pos_ff),
      .decode   (dir_ff),
      .run_data (xf_data)
   );

   assign rsp_valid      = s_valid_ff;
   assign rsp_out_byte   = s_data_ff[s_idx_ff];
   assign rsp_run_last   = run_last;
   assign rsp_stream_end = run_last && s_end_ff;

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         key3_ff     <= '0;
         key5_ff     <= '0;
         key7_ff     <= '0;
         length_ff   <= '0;
         dir_ff      <= 1'b0;
         swap_pos_ff <= 3'd1;
         pos_ff      <= '0;
         blk_base_ff <= '0;
         fill_ff     <= '0;
         prod_ff     <= '0;
         qv_ff       <= '0;
         s_valid_ff  <= 1'b0;
         s_idx_ff    <= '0;
         s_fill_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               kbs_pkg::CSR_KEY: begin
                  key_ff  <= csr_wdata;
                  key3_ff <= csr_wdata + (csr_wdata << 1);
                  key5_ff <= csr_wdata + (csr_wdata << 2);
                  key7_ff <= (csr_wdata << 3) - csr_wdata;
               end
               kbs_pkg::CSR_LENGTH: begin
                  length_ff   <= len_new;
                  swap_pos_ff <= 3'd1 + kbs_pkg::mod7(32'(len_new));
               end
               kbs_pkg::CSR_DIRECTION: begin
                  dir_ff <= csr_wdata[0];
               end
               default: begin
                  // unmapped index: drop the write
               end
            endcase
         end

         if (req_accept) begin
            fill_ff <= complete ? 3'd0 : 3'(fill_new);
            pos_ff  <= at_end ? '0 : pos_ff + LB'(1);
            if (complete) begin
               blk_base_ff <= at_end ? '0 : blk_base_ff + LB'(NB);
               prod_ff     <= at_end ? '0 : prod_ff + (key_ff << 3);
            end
         end

         if (mul_start) begin
            blk_base_ff <= mul_base;
         end
         if (mul_done) begin
            prod_ff <= mul_product;
         end

         qv_ff <= qv_in;

         if (s_load) begin
            s_valid_ff <= 1'b1;
            s_idx_ff   <= '0;
            s_fill_ff  <= q_ff[0].fill;
         end else if (rsp_accept) begin
            if (run_last) begin
               s_valid_ff <= 1'b0;
            end else begin
               s_idx_ff <= s_idx_ff + 3'd1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         blk_buf_ff[fill_ff] <= req_in_byte;
      end
      q_ff <= q_in;
      if (s_load) begin
         s_data_ff <= xf_data;
         s_end_ff  <= q_ff[0].last;
      end
   end

   // ---------------------------------------------------------------- checks
   `KBS_ASSERT_IMP(a_no_accept_in_mul, clock, reset, mul_busy, !req_accept)
   `KBS_ASSERT_IMP(a_queue_room, clock, reset, push, !qv_ff[1])
   `KBS_ASSERT_IMP(a_run_index, clock, reset, s_valid_ff, ({1'b0, s_idx_ff} < s_fill_ff))
   `KBS_ASSERT_NXT(a_stream_restart, clock, reset, req_accept && at_end, (pos_ff == '0) && (fill_ff == '0))

endmodule

// ===== rtl/kbs_mul.sv =====
// Shift-add multiplier that rebuilds block base times key after a register write.
// Depends on kbs_pkg for the key width and default length width.
module kbs_mul #(
   parameter int MPLIER_W = kbs_pkg::LENGTH_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [kbs_pkg::KEY_W-1:0]  start_mcand,
   input  logic [MPLIER_W-1:0]        start_mplier,
   output logic                       busy,
   output logic                       done,
   output logic [kbs_pkg::KEY_W-1:0]  product
);

   localparam int CNT_W = $clog2(MPLIER_W + 1);

   logic                      run_ff;
   logic                      done_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [kbs_pkg::KEY_W-1:0] acc_ff;
   logic [kbs_pkg::KEY_W-1:0] mcand_ff;
   logic [MPLIER_W-1:0]       mplier_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(MPLIER_W);
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // one multiplier bit per cycle, lowest first
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= start_mcand;
         mplier_ff <= start_mplier;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign busy    = run_ff || done_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/kbs_block_xform.sv =====
// Keystream generation, XOR and offset swap for one buffered block.
// Depends on kbs_pkg for block_type and widths.
module kbs_block_xform (
   input  kbs_pkg::block_type                                   blk,
   input  logic [kbs_pkg::BLOCK_BYTES-1:0][kbs_pkg::KEY_W-1:0]  key_mul,
   input  logic [2:0]                                           swap_pos,
   input  logic                                                 decode,
   output logic [kbs_pkg::BLOCK_BYTES-1:0][kbs_pkg::BYTE_W-1:0] run_data
);

   logic [kbs_pkg::BLOCK_BYTES-1:0][kbs_pkg::KEY_W-1:0]  ks_sum;
   logic [kbs_pkg::BLOCK_BYTES-1:0][kbs_pkg::BYTE_W-1:0] ks_byte;
   logic [kbs_pkg::BLOCK_BYTES-1:0][2:0]                 src;

   // byte d of (base + d) * key
   always_comb begin
      for (int d = 0; d < kbs_pkg::BLOCK_BYTES; d++) begin
         ks_sum[d]  = blk.prod + key_mul[d];
         ks_byte[d] = ks_sum[d][kbs_pkg::BYTE_W*d +: kbs_pkg::BYTE_W];
      end
   end

   // encode carries the source keystream, decode the destination's
   always_comb begin
      for (int d = 0; d < kbs_pkg::BLOCK_BYTES; d++) begin
         priority if (blk.swap && d == 0) begin
            src[d] = swap_pos;
         end else if (blk.swap && 3'(d) == swap_pos) begin
            src[d] = 3'd0;
         end else begin
            src[d] = 3'(d);
         end
         if (decode) begin
            run_data[d] = blk.data[src[d]] ^ ks_byte[d];
         end else begin
            run_data[d] = blk.data[src[d]] ^ ks_byte[src[d]];
         end
      end
   end

endmodule

// ===== bench/keyed_byte_scrambler_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for keyed_byte_scrambler: a directed table, then randomized
// streams, checked against a behavioral model or a typed byte. Needs kbs_pkg and the RTL.
module keyed_byte_scrambler_test;

   localparam int ITEM_TARGET   = 280;
   localparam int SETTLE_CYCLES = 12;      // extra wait once every owed byte is seen
   localparam int CYCLE_LIMIT   = 200000;

   // One output byte as the response channel carries it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } out_beat_type;

   typedef enum logic {ROW_CSR, ROW_DATA} row_kind_type;

   // One line of the directed table: a register write or a data byte.
   typedef struct packed {
      row_kind_type           kind;
      kbs_pkg::csr_index_type index;
      logic [63:0]            value;   // register value, or the data byte in bits 7:0
      logic                   typed;   // expected byte is given in want
      logic [7:0]             want;
   } step_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [kbs_pkg::BYTE_W-1:0]      req_in_byte;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [kbs_pkg::BYTE_W-1:0]      rsp_out_byte;
   logic                            rsp_run_last;
   logic                            rsp_stream_end;
   logic                            csr_wr_en;
   logic [kbs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [kbs_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // Behavioral copy of the scrambler: registers and stream state.
   logic [63:0] sc_key;
   logic [31:0] sc_len;
   logic        sc_dir;
   logic [31:0] sc_pos;
   logic [7:0]  sc_buf [8];
   int          sc_fill;

   out_beat_type fresh_beats [$];     // beats released by the latest request
   out_beat_type pending_beats [$];   // beats still owed by the block, oldest first
   step_row_type directed_rows [$];

   logic        tx_calm;             // sender runs without gaps
   logic        rx_calm;             // receiver runs without stalls
   int          rx_hold;
   int          cycle_count;
   int          failures;
   int          items_sent;
   int          beats_seen;
   int          stream_ends;
   int          phase_count;

   keyed_byte_scrambler u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Byte d of (block product + d*key): the keystream of offset d in a block.
   function automatic logic [7:0] keystream_byte(input logic [63:0] base_prod, input int d);
      logic [63:0] p;
      p = base_prod + 64'(d) * sc_key;
      return p[8*d +: 8];
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input step_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Store one raw byte; when the block fills or the stream ends, transform the
   // whole block and append its beats to fresh_beats.
   function automatic void scramble_byte(input logic [7:0] b);
      logic         at_end;
      logic         swap;
      logic [31:0]  base;
      logic [63:0]  prod;
      int           s;
      int           src;
      int           ks;
      out_beat_type beat;
      at_end = (sc_len == 32'd0) || (33'(sc_pos) + 33'd1 >= 33'(sc_len));
      sc_buf[sc_fill % 8] = b;
      sc_fill = sc_fill % 8 + 1;
      if (sc_fill >= 8 || at_end) begin
         // zero length keeps every byte at position 0
         base = ((sc_len == 32'd0) ? 32'd0 : sc_pos) - 32'(sc_fill - 1);
         s    = 1 + int'(sc_len % 32'd7);
         // the stream's final block never swaps
         swap = (33'(base) + 33'd8 < 33'(sc_len)) && (s < sc_fill);
         prod = 64'(base) * sc_key;
         for (int d = 0; d < sc_fill; d++) begin
            src = d;
            if (swap && d == 0) begin
               src = s;
            end else if (swap && d == s) begin
               src = 0;
            end
            // encode carries the source keystream, decode the destination one
            ks = (sc_dir == 1'b0) ? src : d;
            beat.out_byte   = sc_buf[src] ^ keystream_byte(prod, ks);
            beat.run_last   = (d + 1 == sc_fill);
            beat.stream_end = at_end && (d + 1 == sc_fill);
            fresh_beats.insert(fresh_beats.size(), beat);
         end
         sc_fill = 0;
      end
      sc_pos = at_end ? 32'd0 : sc_pos + 32'd1;
   endfunction

   // Present one request after a random gap, hold it until accepted, then predict.
   task automatic send_byte(input logic [7:0] b, input logic typed, input logic [7:0] want);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      fresh_beats.delete();
      scramble_byte(b);
      if (typed) begin
         // rows whose answer is known by inspection: one byte, both flags
         pending_beats.insert(pending_beats.size(), '{want, 1'b1, 1'b1});
      end else begin
         foreach (fresh_beats[k]) pending_beats.insert(pending_beats.size(), fresh_beats[k]);
      end
      items_sent++;
   endtask

   // Write one register while the request channel is idle.
   task automatic write_csr(input kbs_pkg::csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         kbs_pkg::CSR_KEY:       sc_key = value;
         kbs_pkg::CSR_LENGTH:    sc_len = value[31:0];
         kbs_pkg::CSR_DIRECTION: sc_dir = value[0];
         default:                ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drop valid, wait for every owed byte, then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: hold stall for the cycles drawn at the last accepted byte.
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_stall <= 1'b1;
         rx_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted byte with the oldest prediction, field by field.
   always @(posedge clock) begin
      out_beat_type want_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected output byte %02h with nothing predicted", rsp_out_byte);
            failures++;
         end else begin
            want_beat = pending_beats.pop_front();
            if (rsp_out_byte !== want_beat.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want_beat.out_byte, rsp_out_byte);
               failures++;
            end
            if (rsp_run_last !== want_beat.run_last) begin
               $error("run_last: expected %0b, got %0b", want_beat.run_last, rsp_run_last);
               failures++;
            end
            if (rsp_stream_end !== want_beat.stream_end) begin
               $error("stream_end: expected %0b, got %0b",
                      want_beat.stream_end, rsp_stream_end);
               failures++;
            end
         end
         beats_seen++;
         if (rsp_stream_end === 1'b1) stream_ends++;
         rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
      end
   end

   // Watchdog: end the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still owed",
                  cycle_count, pending_beats.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [63:0] new_key;
      logic [31:0] new_len;
      int          burst;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = kbs_pkg::CSR_KEY;
      csr_wdata   = '0;
      sc_key      = '0;
      sc_len      = '0;
      sc_dir      = 1'b0;
      sc_pos      = '0;
      sc_fill     = 0;
      foreach (sc_buf[k]) sc_buf[k] = '0;
      tx_calm     = 1'b0;
      rx_calm     = 1'b0;
      rx_hold     = 0;
      cycle_count = 0;
      failures    = 0;
      items_sent  = 0;
      beats_seen  = 0;
      stream_ends = 0;
      phase_count = 0;

      // Zero length after reset: every byte is a stream of its own and passes
      // unchanged, also with the widest key and in decode.
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h00, 1'b1, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'hFF, 1'b1, 8'hFF});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h5A, 1'b1, 8'h5A});
      add_row('{ROW_CSR, kbs_pkg::CSR_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'hA5, 1'b1, 8'hA5});
      add_row('{ROW_CSR, kbs_pkg::CSR_DIRECTION, 64'd1, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h3C, 1'b1, 8'h3C});
      // Ten-byte encode: one swapped block, then a short final block.
      add_row('{ROW_CSR, kbs_pkg::CSR_DIRECTION, 64'd0, 1'b0, 8'h00});
      add_row('{ROW_CSR, kbs_pkg::CSR_LENGTH, 64'd10, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h80, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h7F, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h01, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'hFE, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h55, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'hAA, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h00, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'hFF, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'h11, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'hEE, 1'b0, 8'h00});
      // One-byte stream: position zero carries a zero keystream.
      add_row('{ROW_CSR, kbs_pkg::CSR_LENGTH, 64'd1, 1'b0, 8'h00});
      add_row('{ROW_CSR, kbs_pkg::CSR_KEY, 64'h0123_4567_89AB_CDEF, 1'b0, 8'h00});
      add_row('{ROW_CSR, kbs_pkg::CSR_DIRECTION, 64'd1, 1'b0, 8'h00});
      add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'hC3, 1'b1, 8'hC3});
      // Nine-byte decode: a full swapped block and a single-byte final block.
      add_row('{ROW_CSR, kbs_pkg::CSR_LENGTH, 64'd9, 1'b0, 8'h00});
      for (int k = 0; k < 9; k++) begin
         add_row('{ROW_DATA, kbs_pkg::CSR_KEY, 64'(8'h10 * k + k), 1'b0, 8'h00});
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_byte(directed_rows[r].value[7:0], directed_rows[r].typed,
                      directed_rows[r].want);
         end
      end

      // Random phases: drain, rewrite some registers, then stream bytes. Most
      // bursts are whole streams; some stop mid-stream so the next length or
      // key lands on a partly filled block.
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         phase_count++;
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0:       new_key = '0;
               1:       new_key = '1;
               default: new_key = {$urandom, $urandom};
            endcase
            write_csr(kbs_pkg::CSR_KEY, new_key);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 19))
               0:          new_len = 32'd0;
               1:          new_len = 32'hFFFF_FFFF;
               2:          new_len = $urandom;
               3, 4, 5, 6: new_len = $urandom_range(1, 8);
               default:    new_len = $urandom_range(9, 40);
            endcase
            // upper word carries noise the length register must ignore
            write_csr(kbs_pkg::CSR_LENGTH, {32'($urandom), new_len});
         end
         if ($urandom_range(0, 1) == 1) begin
            write_csr(kbs_pkg::CSR_DIRECTION,
                      {32'($urandom), 31'($urandom), 1'($urandom_range(0, 1))});
         end
         if (sc_len == 32'd0) begin
            burst = $urandom_range(1, 12);
         end else if (sc_len > 32'd64) begin
            burst = $urandom_range(5, 40);
         end else begin
            burst = int'(sc_len) * $urandom_range(1, 3);
         end
         if ($urandom_range(0, 5) == 0) burst = $urandom_range(1, 30);
         // keep the total close to the target
         if (burst > ITEM_TARGET - items_sent) burst = ITEM_TARGET - items_sent;
         for (int k = 0; k < burst; k++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 8'h00);
         end
      end

      wait_idle();
      $display("Sent %0d requests over %0d register phases; checked %0d output bytes,",
               items_sent, phase_count, beats_seen);
      $display("%0d of them closing a stream, with random gaps and stalls on both sides.",
               stream_ends);
      if (failures == 0 && pending_beats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kbs_pkg.sv
rtl/kbs_mul.sv
rtl/kbs_block_xform.sv
rtl/keyed_byte_scrambler.sv
bench/keyed_byte_scrambler_test.sv
